// ===== rtl/fps_pkg.sv =====
package fps_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int DIM_MAX_DEF    = 16;
  localparam int MAX_REPS_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int DIST_W      = 40;
  localparam int REP_INDEX_W = 10;
  localparam int NUM_REPS_W  = 7;
  localparam int DIMS_W      = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  typedef logic [CFG_ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_NUM_REPS = reg_idx_t'(0);
  localparam reg_idx_t REG_DIMS     = reg_idx_t'(1);

  localparam logic [NUM_REPS_W-1:0] NUM_REPS_RST = NUM_REPS_W'(8);
  localparam logic [DIMS_W-1:0]     DIMS_RST     = DIMS_W'(3);

  localparam logic CMD_CENTROID = 1'b0;
  localparam logic CMD_POINT    = 1'b1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_FEW,
    S_SCAN,
    S_DRAIN,
    S_EMIT,
    S_COPY,
    S_SETTLE
  } state_t;

  typedef struct packed {
    logic load;
    logic job_init;
    logic job_end;
    logic clear_best;
    logic issue;
    logic first_k;
    logic last_k;
    logic copy;
    logic pass_cent;
    logic pass_rep1;
    logic push;
    logic push_seq;
    logic push_last;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/fps_in_if.sv =====
interface fps_in_if #(
  parameter int COORD_BITS = fps_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] coord_value;
  logic                         last_of_set;

  modport source (output valid, cmd, coord_value, last_of_set, input ready);
  modport sink   (input valid, cmd, coord_value, last_of_set, output ready);
endinterface

// ===== rtl/fps_out_if.sv =====
interface fps_out_if;
  logic                               valid;
  logic                               ready;
  logic [fps_pkg::REP_INDEX_W-1:0]    rep_index;
  logic                               last_rep;
  logic                               overflowed;

  modport source (output valid, rep_index, last_rep, overflowed, input ready);
  modport sink   (input valid, rep_index, last_rep, overflowed, output ready);
endinterface

// ===== rtl/fps_ctrl.sv =====
module fps_ctrl #(
  parameter int MAX_POINTS = fps_pkg::MAX_POINTS_DEF,
  parameter int DIM_MAX    = fps_pkg::DIM_MAX_DEF,
  parameter int MAX_REPS   = fps_pkg::MAX_REPS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic                                              in_last,
  output logic                                              in_ready,
  input  logic [$clog2(DIM_MAX+1)-1:0]                      nd,
  input  logic [$clog2(MAX_REPS+1)-1:0]                     n,
  input  logic [$clog2(MAX_POINTS+1)-1:0]                   npts,
  input  fps_pkg::stat_t                                    stat,
  output fps_pkg::ctl_t                                     ctl,
  output logic [$clog2(MAX_POINTS)-1:0]                     idx,
  output logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0]  kpos
);
  import fps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS+1);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int DIM_W  = $clog2(DIM_MAX+1);
  localparam int KPOS_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int REP_W  = $clog2(MAX_REPS+1);

  state_t state, state_next;
  logic [CNT_W-1:0]  j;
  logic [KPOS_W-1:0] k;
  logic [REP_W-1:0]  rep;

  logic k_last, j_last, rep_last, few;

  assign k_last   = (DIM_W'(k) + DIM_W'(1)) == nd;
  assign j_last   = (j + CNT_W'(1)) == npts;
  assign rep_last = (rep + REP_W'(1)) == n;
  assign few      = 32'(n) >= 32'(npts);
  assign idx      = IDX_W'(j);
  assign kpos     = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      j     <= '0;
      k     <= '0;
      rep   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_START: begin
          j   <= '0;
          k   <= '0;
          rep <= '0;
        end
        S_FEW: begin
          if (stat.out_free) j <= j + CNT_W'(1);
        end
        S_SCAN: begin
          if (k_last) begin
            k <= '0;
            j <= j + CNT_W'(1);
          end else begin
            k <= k + KPOS_W'(1);
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            rep <= rep + REP_W'(1);
            j   <= '0;
            k   <= '0;
          end
        end
        S_COPY: begin
          k <= k_last ? '0 : k + KPOS_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (in_valid && in_last) state_next = S_START;
      S_START: begin
        if (npts == '0)  state_next = S_LOAD;
        else if (few)    state_next = S_FEW;
        else             state_next = S_SCAN;
      end
      S_FEW:    if (stat.out_free && j_last) state_next = S_LOAD;
      S_SCAN:   if (j_last && k_last) state_next = S_DRAIN;
      S_DRAIN:  if (!stat.busy) state_next = S_EMIT;
      S_EMIT:   if (stat.out_free) state_next = rep_last ? S_LOAD : S_COPY;
      S_COPY:   if (k_last) state_next = S_SETTLE;
      S_SETTLE: state_next = S_SCAN;
      default:  state_next = S_LOAD;
    endcase
  end

  always_comb begin
    ctl           = '0;
    in_ready      = 1'b0;
    ctl.pass_cent = (rep == '0);
    ctl.pass_rep1 = (rep == REP_W'(1));
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_START: begin
        if (npts == '0) begin
          ctl.job_end = 1'b1;
        end else if (!few) begin
          ctl.job_init   = 1'b1;
          ctl.clear_best = 1'b1;
        end
      end
      S_FEW: begin
        ctl.push      = stat.out_free;
        ctl.push_seq  = 1'b1;
        ctl.push_last = j_last;
        ctl.job_end   = stat.out_free && j_last;
      end
      S_SCAN: begin
        ctl.issue   = 1'b1;
        ctl.first_k = (k == '0);
        ctl.last_k  = k_last;
      end
      S_EMIT: begin
        ctl.push       = stat.out_free;
        ctl.push_last  = rep_last;
        ctl.job_end    = stat.out_free && rep_last;
        ctl.clear_best = stat.out_free && !rep_last;
      end
      S_COPY: ctl.copy = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/fps_datapath.sv =====
module fps_datapath #(
  parameter int MAX_POINTS = fps_pkg::MAX_POINTS_DEF,
  parameter int DIM_MAX    = fps_pkg::DIM_MAX_DEF,
  parameter int COORD_BITS = fps_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  fps_pkg::ctl_t                                     ctl,
  input  logic [$clog2(MAX_POINTS)-1:0]                     idx,
  input  logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0]  kpos,
  input  logic [$clog2(DIM_MAX+1)-1:0]                      nd,
  input  logic                                              cmd,
  input  logic signed [COORD_BITS-1:0]                      coord_value,
  output logic [$clog2(MAX_POINTS+1)-1:0]                   npts,
  output fps_pkg::stat_t                                    stat,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [fps_pkg::REP_INDEX_W-1:0]                   rep_index,
  output logic                                              last_rep,
  output logic                                              overflowed
);
  import fps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS+1);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int DIM_W  = $clog2(DIM_MAX+1);
  localparam int KPOS_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int PDEPTH = MAX_POINTS * DIM_MAX;
  localparam int PA_W   = $clog2(PDEPTH);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;

  logic [COORD_BITS-1:0] pmem [PDEPTH];
  logic [DIST_W-1:0]     mmem [MAX_POINTS];
  logic [COORD_BITS-1:0] cent [DIM_MAX];
  logic [COORD_BITS-1:0] refc [DIM_MAX];

  // ---- loading ----
  logic [DIM_W-1:0] pos, pos_eff, pos_inc;
  logic             ovf;
  logic             room, pwr;
  logic [PA_W-1:0]  waddr, raddr;
  logic [IDX_W-1:0] chosen;
  logic [IDX_W-1:0] ridx;

  assign pos_eff = (pos >= nd) ? '0 : pos;
  assign pos_inc = pos_eff + DIM_W'(1);
  assign room    = 32'(npts) < MAX_POINTS;
  assign pwr     = ctl.load && (cmd == CMD_POINT) && room;
  assign waddr   = PA_W'(npts) * PA_W'(DIM_MAX) + PA_W'(pos_eff);
  assign ridx    = ctl.copy ? chosen : idx;
  assign raddr   = PA_W'(ridx) * PA_W'(DIM_MAX) + PA_W'(kpos);

  always_ff @(posedge clk) begin
    if (rst || ctl.job_end) begin
      pos  <= '0;
      npts <= '0;
      ovf  <= 1'b0;
    end else if (ctl.load) begin
      if (cmd == CMD_POINT && !room) ovf <= 1'b1;
      if (pos_inc >= nd) begin
        pos <= '0;
        if (cmd == CMD_POINT && room) npts <= npts + CNT_W'(1);
      end else begin
        pos <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && cmd == CMD_CENTROID) cent[KPOS_W'(pos_eff)] <= coord_value;
  end

  always_ff @(posedge clk) begin
    if (pwr) pmem[waddr] <= coord_value;
  end

  // ---- distance pipeline ----
  logic [COORD_BITS-1:0] prd;
  logic                  vb, fb, lb, cb;
  logic [IDX_W-1:0]      jb;
  logic [KPOS_W-1:0]     kb;
  logic [COORD_BITS-1:0] refb;

  always_ff @(posedge clk) begin
    if (ctl.issue || ctl.copy) prd <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      cb <= 1'b0;
    end else begin
      vb <= ctl.issue;
      cb <= ctl.copy;
    end
    fb   <= ctl.first_k;
    lb   <= ctl.last_k;
    jb   <= idx;
    kb   <= kpos;
    refb <= ctl.pass_cent ? cent[kpos] : refc[kpos];
  end

  always_ff @(posedge clk) begin
    if (cb) refc[kb] <= prd;
  end

  logic signed [DIFF_W-1:0]     diff;
  logic signed [2*DIFF_W-1:0]   prod;
  logic                         vc, fc, lc;
  logic [IDX_W-1:0]             jc;
  logic [SQ_W-1:0]              sqc;

  assign diff = $signed({prd[COORD_BITS-1], prd}) - $signed({refb[COORD_BITS-1], refb});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
    fc  <= fb;
    lc  <= lb;
    jc  <= jb;
    sqc <= SQ_W'(unsigned'(prod));
  end

  logic [DIST_W-1:0] acc, mrd, mval, best;
  logic              dd;
  logic [IDX_W-1:0]  jd;

  always_ff @(posedge clk) begin
    if (rst) dd <= 1'b0;
    else     dd <= vc && lc;
    jd <= jc;
    if (vc) acc <= fc ? DIST_W'(sqc) : acc + DIST_W'(sqc);
  end

  always_ff @(posedge clk) begin
    if (vc && lc) mrd <= mmem[jc];
  end

  // the rep 1 pass has no stored minimum yet, so the read value is ignored
  assign mval = (ctl.pass_cent || ctl.pass_rep1 || acc < mrd) ? acc : mrd;

  always_ff @(posedge clk) begin
    if (dd && !ctl.pass_cent) mmem[jd] <= mval;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.job_init) begin
      chosen <= '0;
      best   <= '0;
    end else if (ctl.clear_best) begin
      best <= '0;
    end else if (dd && mval > best) begin
      best   <= mval;
      chosen <= jd;
    end
  end

  // ---- result register ----
  assign stat.busy     = vb || vc || dd;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.push) begin
      rep_index  <= REP_INDEX_W'(ctl.push_seq ? idx : chosen);
      last_rep   <= ctl.push_last;
      overflowed <= ovf;
    end
  end

endmodule

// ===== rtl/farthest_point_sampler_core.sv =====
// Farthest point sampler. Load one centroid coordinate (cmd 0) or point
// coordinate (cmd 1) per beat, one beat per cycle; the beat with last_of_set
// starts selection and the input stalls until the last pick is registered.
// First pick: farthest point from the centroid; each later pick maximizes the
// smallest distance to the picks so far (ties to lower index). Picks stream
// out in order, last_rep on the final one. If num_reps >= points, indices
// 0..points-1 come out, one per cycle unless the output stalls. Otherwise
// each pick reads every coordinate of every point, one per cycle, via the
// single point memory read port, later picks after copying the last pick.
// Registers: num_reps 0x0, dims 0x4; write only while idle (unchecked).
module farthest_point_sampler_core #(
  parameter int MAX_POINTS = fps_pkg::MAX_POINTS_DEF,
  parameter int DIM_MAX    = fps_pkg::DIM_MAX_DEF,
  parameter int MAX_REPS   = fps_pkg::MAX_REPS_DEF,
  parameter int COORD_BITS = fps_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  fps_in_if.sink                           in_ch,
  fps_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import fps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS+1);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int DIM_W  = $clog2(DIM_MAX+1);
  localparam int KPOS_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int REP_W  = $clog2(MAX_REPS+1);

  logic [NUM_REPS_W-1:0] num_reps;
  logic [DIMS_W-1:0]     dims;
  reg_idx_t              reg_sel;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_reps <= NUM_REPS_RST;
      dims     <= DIMS_RST;
    end else if (cfg_wr) begin
      if (reg_sel == REG_NUM_REPS) num_reps <= pwdata[NUM_REPS_W-1:0];
      if (reg_sel == REG_DIMS)     dims     <= pwdata[DIMS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_NUM_REPS)  prdata = CFG_DATA_W'(num_reps);
    else if (reg_sel == REG_DIMS) prdata = CFG_DATA_W'(dims);
  end

  logic [DIM_W-1:0] nd;
  logic [REP_W-1:0] n;

  always_comb begin
    if (dims == '0)               nd = DIM_W'(1);
    else if (int'(dims) > DIM_MAX) nd = DIM_W'(DIM_MAX);
    else                          nd = DIM_W'(dims);
    if (num_reps == '0)                n = REP_W'(1);
    else if (int'(num_reps) > MAX_REPS) n = REP_W'(MAX_REPS);
    else                               n = REP_W'(num_reps);
  end

  ctl_t              ctl;
  stat_t             stat;
  logic [CNT_W-1:0]  npts;
  logic [IDX_W-1:0]  idx;
  logic [KPOS_W-1:0] kpos;

  fps_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .DIM_MAX    (DIM_MAX),
    .MAX_REPS   (MAX_REPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_of_set),
    .in_ready (in_ch.ready),
    .nd       (nd),
    .n        (n),
    .npts     (npts),
    .stat     (stat),
    .ctl      (ctl),
    .idx      (idx),
    .kpos     (kpos)
  );

  fps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .DIM_MAX    (DIM_MAX),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .idx         (idx),
    .kpos        (kpos),
    .nd          (nd),
    .cmd         (in_ch.cmd),
    .coord_value (in_ch.coord_value),
    .npts        (npts),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .rep_index   (out_ch.rep_index),
    .last_rep    (out_ch.last_rep),
    .overflowed  (out_ch.overflowed)
  );

  a_npts_bound: assert property (@(posedge clk) disable iff (rst)
    32'(npts) <= MAX_POINTS)
    else $error("point count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> 32'(idx) < 32'(npts))
    else $error("scan index beyond loaded points");

  a_seq_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && ctl.push_seq) |-> 32'(idx) < 32'(npts))
    else $error("sequential pick beyond loaded points");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> stat.out_free)
    else $error("result pushed over a pending beat");

endmodule
